[design/bmp_pkg.sv]
// Package for the middle-pop buffer: sizes, status codes and word types.
`timescale 1ns / 1ps

package bmp_pkg;

    // Capacity of the buffer and the widths that follow from it.
    localparam int DEPTH      = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W     = 32;
    localparam int CNT_OUT_W  = 5;

    // Request codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request word.
    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } bmp_req_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [4:0]         element_count;
    } bmp_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } bmp_cmd_t;

endpackage

[design/bmp_ctrl.sv]
// Controller for the middle-pop buffer: request sequencing and result strobe.
`timescale 1ns / 1ps

module bmp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output bmp_pkg::bmp_cmd_t cmd
);
    import bmp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next state: a request is captured in idle and carried out in S_EXEC.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Commands and status towards the ports.
    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.execute = (state_reg == S_EXEC);

endmodule

[design/bmp_datapath.sv]
// Datapath for the middle-pop buffer: element cells, count and result word.
`timescale 1ns / 1ps

module bmp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bmp_pkg::bmp_cmd_t cmd,
    input  bmp_pkg::bmp_req_t req,
    output bmp_pkg::bmp_rsp_t result
);
    import bmp_pkg::*;

    bmp_req_t                  req_reg;
    logic [DATA_W-1:0]         cell_reg  [DEPTH];
    logic [DATA_W-1:0]         cell_next [DEPTH];
    logic [CNT_W-1:0]          count_reg, count_next;
    bmp_rsp_t                  rsp_reg, rsp_next;

    logic                      is_full;
    logic                      is_empty;
    logic [CNT_W-1:0]          count_m1;
    logic [CNT_W-1:0]          half;
    logic [IDX_W-1:0]          pop_idx;
    logic [IDX_W-1:0]          wr_idx;
    logic                      do_push;
    logic                      do_pop;

    // Decode of the held request against the current fill.
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);
    assign half     = count_m1 >> 1;
    assign pop_idx  = half[IDX_W-1:0];
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign do_push  = cmd.execute && (req_reg.op == OP_PUSH) && !is_full;
    assign do_pop   = cmd.execute && (req_reg.op == OP_POP) && !is_empty;

    // Cell update: a push writes at the end, a pop pulls every later cell down.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_push && (wr_idx == IDX_W'(i)))
            begin
                cell_next[i] = req_reg.value;
            end
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            if (do_pop && (CNT_W'(i) >= half) && (CNT_W'(i + 1) < count_reg))
            begin
                cell_next[i] = cell_reg[i + 1];
            end
        end
    end

    // Count and result word.
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (cmd.execute)
        begin
            rsp_next.popped_value = '0;
            rsp_next.status       = ST_OK;
            if (req_reg.op == OP_PUSH)
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.popped_value = cell_reg[pop_idx];
                    count_next            = count_m1;
                end
            end
            rsp_next.element_count = CNT_OUT_W'(count_next);
        end
    end

    // Fill count is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        cell_reg <= cell_next;
        rsp_reg  <= rsp_next;
    end

    assign result = rsp_reg;

endmodule

[design/bag_middle_pop_buffer_top.sv]
// Top level of the middle-pop buffer: controller and datapath joined.
`timescale 1ns / 1ps

// Ordered buffer of up to DEPTH signed 32-bit elements (16 as built).
// Request channel: req carries op (push or pop) and value. A request word is
// taken at a rising edge where start is high and busy is low.
// A push appends value at the end; a pop removes the element at position
// (count-1)/2 and moves every later element down one place.
// Result channel: done is high for exactly one cycle while result holds the
// popped value, a status (ok, pop on empty, push on full) and the count after
// the request. The receiver cannot hold a result off; it must take it then.
// A request taken at a rising edge is carried out in the execute state, and its
// result word is registered and shown together with done.
// The two-state controller (capture, then execute) takes one request at a time;
// busy is high in the execute cycle and no request is taken then; the next
// request may be taken in the same cycle as the previous result is shown.
// Reset (rst_n low, asynchronous) empties the buffer and clears the strobe;
// element contents are not cleared and are never read before written.
module bag_middle_pop_buffer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bmp_pkg::bmp_req_t req,
    output logic              done,
    output bmp_pkg::bmp_rsp_t result
);
    import bmp_pkg::*;

    bmp_cmd_t cmd;

    // Sequencing.
    bmp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Storage and result formation.
    bmp_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .result (result)
    );

endmodule

[sim/tb_bag_middle_pop_buffer_top.sv]
// Self-checking testbench for the middle-pop buffer with a built-in buffer predictor.
`timescale 1ns / 1ps

module tb_bag_middle_pop_buffer_top;

    import bmp_pkg::*;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    bmp_req_t req   = '0;
    logic     done;
    bmp_rsp_t result;

    // Predicted contents of the buffer, kept in step with accepted request words.
    logic signed [31:0] shadow_store [DEPTH];
    int                 shadow_count = 0;

    // Result words still to come, oldest first.
    bmp_rsp_t awaited_results [$];
    int       failures = 0;

    bag_middle_pop_buffer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Works out the result word of one request and updates the shadow buffer.
    function automatic bmp_rsp_t buffer_outcome(input bmp_req_t w);
        bmp_rsp_t r;
        int       mid;
        r = '0;
        if (w.op == OP_PUSH)
        begin
            if (shadow_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                shadow_store[shadow_count] = w.value;
                shadow_count++;
                r.status = ST_OK;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // Take the middle element, ties to the lower place, and close the gap.
            mid            = (shadow_count - 1) / 2;
            r.popped_value = shadow_store[mid];
            for (int i = mid; i + 1 < shadow_count; i++)
                shadow_store[i] = shadow_store[i + 1];
            shadow_count--;
            r.status = ST_OK;
        end
        r.element_count = 5'(shadow_count);
        return r;
    endfunction

    // Mostly random bits, with the extremes of the signed range mixed in.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // Offers one request word and holds it until the block takes it.
    // The start line is left high so that a following word can go straight out.
    task automatic send_word(input logic op, input logic signed [31:0] value);
        bmp_req_t w;
        w.op    = op;
        w.value = value;
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        awaited_results.push_back(buffer_outcome(w));
    endtask

    // Leaves the request side idle for a while, with junk on the word lines.
    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        req   <= {1'($urandom()), 32'($urandom())};
        repeat (cycles) @(posedge clk);
    endtask

    // A pop straight after reset must report an empty buffer.
    task automatic test_pop_on_empty();
        send_word(OP_POP, 32'sh1234_5678);
    endtask

    // Extremes of the value field go in and one comes back out of the middle.
    task automatic test_value_extremes();
        send_word(OP_PUSH, 32'sh8000_0000);
        send_word(OP_PUSH, 32'sh7fff_ffff);
        send_word(OP_PUSH, 32'sd0);
        send_word(OP_PUSH, -32'sd1);
        send_word(OP_PUSH, 32'sd1);
        send_word(OP_POP, -32'sd1);
    endtask

    // Filling to capacity, then one more push that must be turned away.
    task automatic test_fill_to_capacity();
        while (shadow_count < DEPTH)
            send_word(OP_PUSH, shadow_count[0] ? 32'shaaaa_aaaa : 32'sh5555_5555 + shadow_count);
        send_word(OP_PUSH, 32'sh0bad_cafe);
    endtask

    // Pops from a full buffer, so the middle place moves as the count falls.
    task automatic test_middle_removal();
        repeat (4) send_word(OP_POP, pick_value());
    endtask

    // Random segments that lean towards pushes or pops, or mix them evenly, so the count wanders
    // between empty and full; gaps on the request side are optional.
    task automatic test_random_mix(input int n_items, input bit with_gaps);
        int sent;
        int seg_len;
        int push_pct;
        bit gaps_on;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(5, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_word(OP_PUSH, pick_value());
                else
                    send_word(OP_POP, pick_value());
                sent++;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    idle_burst($urandom_range(1, 18));
            end
        end
    endtask

    // Every strobed result word is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        bmp_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with no request outstanding");
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.popped_value !== want.popped_value)
                begin
                    $error("popped_value: expected %0d, got %0d",
                           want.popped_value, result.popped_value);
                    failures++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    failures++;
                end
                if (result.element_count !== want.element_count)
                begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, result.element_count);
                    failures++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin : run_tests
        int guard;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_pop_on_empty();
        test_value_extremes();
        test_fill_to_capacity();
        test_middle_removal();
        test_random_mix(1400, 1'b1);
        test_random_mix(330, 1'b0);
        start <= 1'b0;

        // Let the outstanding results drain, then allow for the pipeline.
        guard = 0;
        while (awaited_results.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d result words never arrived", awaited_results.size());
            failures++;
        end

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
design/bmp_pkg.sv
design/bmp_ctrl.sv
design/bmp_datapath.sv
design/bag_middle_pop_buffer_top.sv
sim/tb_bag_middle_pop_buffer_top.sv
